### sv/nfd_pkg.sv
// Package for the NEC IR frame decoder: widths, register indexes, reset values,
// the pulse class code and the packed result word. No dependencies.
package nfd_pkg;

	// Field and port widths.
	localparam int CFG_W       = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int WIDTH_W     = 8;
	localparam int BYTE_W      = 8;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	// Default number of bytes in one frame.
	localparam int FRAME_BYTES_DEF = 4;

	// Depth of the queue between classifier and executor.
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MAX = 3'd5;

	// Register reset values.
	localparam logic [CFG_W-1:0] RST_ZERO_MIN   = 8'h01;
	localparam logic [CFG_W-1:0] RST_ZERO_MAX   = 8'h03;
	localparam logic [CFG_W-1:0] RST_ONE_MIN    = 8'h07;
	localparam logic [CFG_W-1:0] RST_ONE_MAX    = 8'h09;
	localparam logic [CFG_W-1:0] RST_LEADER_MIN = 8'h14;
	localparam logic [CFG_W-1:0] RST_LEADER_MAX = 8'h16;

	// Class of one IR event as decided by the front end.
	typedef enum logic [2:0] {
		CLS_TIMEOUT,
		CLS_ZERO,
		CLS_ONE,
		CLS_LEADER,
		CLS_BAD
	} cls_t;

	// Result word, frame_ready in the lowest bit.
	typedef struct packed {
		logic              aborted;
		logic              receiving;
		logic [BYTE_W-1:0] command;
		logic [BYTE_W-1:0] address;
		logic              frame_ready;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

### sv/nfd_front.sv
// Front end of the NEC IR frame decoder: holds the width range registers and
// classifies each input word into a pulse class. Depends on nfd_pkg.
module nfd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nfd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic                          s_tuser,   // mode
	input  logic [nfd_pkg::IN_TDATA_W-1:0] s_tdata,  // width
	output logic                          out_valid,
	input  logic                          out_ready,
	output nfd_pkg::cls_t                 out_cls
);

	logic [nfd_pkg::CFG_W-1:0] zero_min_q, zero_max_q;
	logic [nfd_pkg::CFG_W-1:0] one_min_q, one_max_q;
	logic [nfd_pkg::CFG_W-1:0] leader_min_q, leader_max_q;
	logic                      vld_s1;
	nfd_pkg::cls_t             cls_s1;
	nfd_pkg::cls_t             cls_next;
	logic                      is_zero, is_one, is_leader;
	logic [nfd_pkg::WIDTH_W-1:0] w;

	// Range registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_min_q   <= nfd_pkg::RST_ZERO_MIN;
			zero_max_q   <= nfd_pkg::RST_ZERO_MAX;
			one_min_q    <= nfd_pkg::RST_ONE_MIN;
			one_max_q    <= nfd_pkg::RST_ONE_MAX;
			leader_min_q <= nfd_pkg::RST_LEADER_MIN;
			leader_max_q <= nfd_pkg::RST_LEADER_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				nfd_pkg::REG_ZERO_MIN:   zero_min_q   <= cfg_data;
				nfd_pkg::REG_ZERO_MAX:   zero_max_q   <= cfg_data;
				nfd_pkg::REG_ONE_MIN:    one_min_q    <= cfg_data;
				nfd_pkg::REG_ONE_MAX:    one_max_q    <= cfg_data;
				nfd_pkg::REG_LEADER_MIN: leader_min_q <= cfg_data;
				nfd_pkg::REG_LEADER_MAX: leader_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Classification; zero wins over one, and both win over leader.
	assign w         = s_tdata;
	assign is_zero   = (w >= zero_min_q) && (w <= zero_max_q);
	assign is_one    = (w >= one_min_q) && (w <= one_max_q);
	assign is_leader = (w >= leader_min_q) && (w <= leader_max_q);

	always_comb begin
		if (s_tuser) begin
			cls_next = nfd_pkg::CLS_TIMEOUT;
		end else if (is_zero) begin
			cls_next = nfd_pkg::CLS_ZERO;
		end else if (is_one) begin
			cls_next = nfd_pkg::CLS_ONE;
		end else if (is_leader) begin
			cls_next = nfd_pkg::CLS_LEADER;
		end else begin
			cls_next = nfd_pkg::CLS_BAD;
		end
	end

	// One output stage; it refills in the cycle it is taken.
	assign s_tready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_cls   = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cls_s1 <= cls_next;
		end
	end

endmodule

### sv/nfd_queue.sv
// Short queue of pulse classes between the front end and the executor of the
// NEC IR frame decoder. Depends on nfd_pkg.
module nfd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  nfd_pkg::cls_t in_cls,
	output logic          out_valid,
	input  logic          out_ready,
	output nfd_pkg::cls_t out_cls
);

	localparam int PTR_W = (nfd_pkg::QUEUE_DEPTH > 1) ? $clog2(nfd_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(nfd_pkg::QUEUE_DEPTH + 1);

	nfd_pkg::cls_t    mem_q [nfd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign in_ready  = (count_q != CNT_W'(nfd_pkg::QUEUE_DEPTH)) || out_ready;
	assign push      = in_valid && in_ready;
	assign out_cls   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(nfd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(nfd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cls;
		end
	end

endmodule

### sv/nfd_back.sv
// Executor of the NEC IR frame decoder: frame state, bit and byte assembly,
// complement check and the output register. Depends on nfd_pkg.
module nfd_back #(
	parameter int FRAME_BYTES = nfd_pkg::FRAME_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  nfd_pkg::cls_t                   in_cls,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [nfd_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int BI_W = $clog2(FRAME_BYTES);

	logic                        active_q;
	logic [nfd_pkg::BYTE_W-1:0]  shift_q;
	logic [2:0]                  bit_q;
	logic [BI_W-1:0]             byte_q;
	logic [nfd_pkg::BYTE_W-1:0]  addr_q, cmd_q;
	logic                        m_valid_q;
	nfd_pkg::result_t            res_q;

	logic                        take;
	logic                        is_bit, bit_val;
	logic [nfd_pkg::BYTE_W-1:0]  sh;
	logic                        byte_done, last_byte;
	nfd_pkg::result_t            res;

	assign in_ready  = !m_valid_q || m_tready;
	assign take      = in_valid && in_ready;
	assign is_bit    = (in_cls == nfd_pkg::CLS_ZERO) || (in_cls == nfd_pkg::CLS_ONE);
	assign bit_val   = (in_cls == nfd_pkg::CLS_ONE);
	assign sh        = {bit_val, shift_q[nfd_pkg::BYTE_W-1:1]};
	assign byte_done = (bit_q == 3'd7);
	assign last_byte = (byte_q == BI_W'(FRAME_BYTES - 1));

	// Result of the word now being taken.
	always_comb begin
		res = '0;
		if (in_cls == nfd_pkg::CLS_LEADER) begin
			res.receiving = 1'b1;
		end else if (!is_bit || !active_q) begin
			res.aborted = 1'b1;
		end else if (byte_done && last_byte) begin
			if (cmd_q == ~sh) begin
				res.frame_ready = 1'b1;
				res.address     = addr_q;
				res.command     = cmd_q;
			end else begin
				res.aborted = 1'b1;
			end
		end else begin
			res.receiving = 1'b1;
		end
	end

	// Frame state; a leader restarts, any error or a finished frame clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			shift_q  <= '0;
			bit_q    <= '0;
			byte_q   <= '0;
		end else if (take) begin
			if (res.receiving) begin
				active_q <= 1'b1;
				if (in_cls == nfd_pkg::CLS_LEADER) begin
					shift_q <= '0;
					bit_q   <= '0;
					byte_q  <= '0;
				end else if (byte_done) begin
					shift_q <= '0;
					bit_q   <= '0;
					byte_q  <= byte_q + 1'b1;
				end else begin
					shift_q <= sh;
					bit_q   <= bit_q + 1'b1;
				end
			end else begin
				active_q <= 1'b0;
				shift_q  <= '0;
				bit_q    <= '0;
				byte_q   <= '0;
			end
		end
	end

	// Address and command bytes are kept as they complete.
	always_ff @(posedge clk) begin
		if (take && active_q && is_bit && byte_done) begin
			if (byte_q == '0) begin
				addr_q <= sh;
			end
			if (byte_q == BI_W'(FRAME_BYTES - 2)) begin
				cmd_q <= sh;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_ready) begin
			m_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(nfd_pkg::OUT_TDATA_W - nfd_pkg::RESULT_W){1'b0}}, res_q};

endmodule

### sv/nec_ir_frame_decoder.sv
// Top level of the NEC IR frame decoder: front end, class queue and executor.
// Depends on nfd_pkg, nfd_front, nfd_queue and nfd_back.
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  s_tuser mode, s_tdata width
//  m_*      out        m_tvalid/m_tready  m_tdata result word
//  cfg_*    in         cfg_we             cfg_index, cfg_data
//
// One word is accepted per cycle while s_tready is high; its result passes the front-end
// stage, a queue entry and the output register before it shows on m_tvalid.
// Reset clears all frame state and loads the default width ranges.
// A stall on m_tready backs up through the queue; the front end keeps accepting
// until its stage and the queue are full.
module nec_ir_frame_decoder #(
	parameter int FRAME_BYTES = nfd_pkg::FRAME_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [nfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nfd_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic                            s_tuser,   // [0] mode
	input  logic [nfd_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] width
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] frame_ready, [8:1] address, [16:9] command, [17] receiving, [18] aborted
	output logic [nfd_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic          f_valid, f_ready;
	nfd_pkg::cls_t f_cls;
	logic          q_valid, q_ready;
	nfd_pkg::cls_t q_cls;

	nfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_cls   (f_cls)
	);

	nfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cls    (f_cls),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cls   (q_cls)
	);

	nfd_back #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_cls   (q_cls),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### sv/nfd_checker.sv
// Port-level checker for the NEC IR frame decoder and its bind to the top level.
// Depends on nfd_pkg and nec_ir_frame_decoder.
module nfd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [nfd_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// A word never reports both a good frame and an abort.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[18]))
		else $error("frame_ready and aborted both set");

	// A finished frame or an abort leaves no frame in progress.
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[0] || m_tdata[18]) |-> !m_tdata[17])
		else $error("receiving set on a closing word");

	// Address and command are zero unless a frame is ready.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[16:1] == '0))
		else $error("payload bytes set without frame_ready");

endmodule

bind nec_ir_frame_decoder nfd_checker u_nfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### verif/tb_nec_ir_frame_decoder.sv
// Self-checking testbench for nec_ir_frame_decoder: directed events, then random
// frames and noise under several width-range settings, checked by a local decoder.
// Depends on nfd_pkg and the nec_ir_frame_decoder RTL.
module tb_nec_ir_frame_decoder;
	import nfd_pkg::*;

	localparam int NBYTES         = FRAME_BYTES_DEF;
	localparam int CMD_IDX        = NBYTES - 2;
	localparam int REG_COUNT      = 6;
	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 125;
	localparam int EMPTY_ITEMS    = 80;
	localparam int NPLAN          = 8;
	localparam int EMPTY_PLAN     = 4;
	localparam int HOLD_AT        = 400;
	localparam int PAUSE_AT       = 900;
	localparam int NDIR           = 24;

	typedef enum logic {ROW_EVENT, ROW_FRAME} row_kind_t;
	typedef enum logic [2:0] {
		FLAW_NONE, FLAW_MISMATCH, FLAW_TIMEOUT, FLAW_BAD, FLAW_RESTART, FLAW_CUT
	} flaw_t;

	// One directed step: a single event, or a whole frame whose address rides in width.
	typedef struct packed {
		row_kind_t         kind;
		flaw_t             flaw;
		logic              mode;
		logic [WIDTH_W-1:0] width;
		logic [BYTE_W-1:0] cmd;
		logic              typed;
		result_t           want;
	} dir_row_t;

	typedef logic [0:REG_COUNT-1][CFG_W-1:0] limits_t;

	localparam result_t R_ABORT = '{aborted: 1'b1, default: '0};
	localparam result_t R_RECV  = '{receiving: 1'b1, default: '0};
	localparam result_t R_NONE  = '0;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic                   s_tuser   = 1'b0;   // [0] mode
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;     // [7:0] width
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	// [0] frame_ready, [8:1] address, [16:9] command, [17] receiving, [18] aborted
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Local copy of the width limits and of the frame reception state.
	logic [CFG_W-1:0]  lim [REG_COUNT] = '{RST_ZERO_MIN, RST_ZERO_MAX, RST_ONE_MIN,
		RST_ONE_MAX, RST_LEADER_MIN, RST_LEADER_MAX};
	logic              rx_open  = 1'b0;
	logic [BYTE_W-1:0] rx_shift = '0;
	int                rx_bits  = 0;
	int                rx_bytes = 0;
	logic [BYTE_W-1:0] rx_buf [NBYTES];

	result_t decoded_q [$];
	int      sent_count    = 0;
	int      taken_count   = 0;
	int      checked_words = 0;
	int      bad_words     = 0;
	int      stuck_cycles  = 0;
	bit      hold_req      = 1'b0;

	cls_t    noise_cls [4] = '{CLS_ZERO, CLS_ONE, CLS_LEADER, CLS_BAD};
	limits_t plan [NPLAN];

	// Directed steps, all under the reset width ranges.
	dir_row_t dir_rows [NDIR] = '{
		'{ROW_EVENT, FLAW_NONE,     1'b1, 8'hFF, 8'h00, 1'b1, R_ABORT},  // timeout, idle
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'h00, 8'h00, 1'b1, R_ABORT},  // width 0 in no range
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'hFF, 8'h00, 1'b1, R_ABORT},  // largest width
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd2,  8'h00, 1'b1, R_ABORT},  // zero while idle
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd8,  8'h00, 1'b1, R_ABORT},  // one while idle
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd20, 8'h00, 1'b1, R_RECV},   // leader at low edge
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd22, 8'h00, 1'b1, R_RECV},   // leader at high edge
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd1,  8'h00, 1'b1, R_RECV},   // zero bit, edges
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd3,  8'h00, 1'b1, R_RECV},
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd7,  8'h00, 1'b1, R_RECV},   // one bit, edges
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd9,  8'h00, 1'b1, R_RECV},
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd21, 8'h00, 1'b1, R_RECV},   // leader mid-data
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd5,  8'h00, 1'b1, R_ABORT},  // between ranges
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd21, 8'h00, 1'b1, R_RECV},
		'{ROW_EVENT, FLAW_NONE,     1'b1, 8'h00, 8'h00, 1'b1, R_ABORT},  // timeout in frame
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd23, 8'h00, 1'b1, R_ABORT},  // just past leader
		'{ROW_EVENT, FLAW_NONE,     1'b0, 8'd19, 8'h00, 1'b1, R_ABORT},  // just below leader
		'{ROW_FRAME, FLAW_NONE,     1'b0, 8'h00, 8'h00, 1'b0, R_NONE},
		'{ROW_FRAME, FLAW_NONE,     1'b0, 8'hFF, 8'hFF, 1'b0, R_NONE},
		'{ROW_FRAME, FLAW_MISMATCH, 1'b0, 8'hA5, 8'h3C, 1'b0, R_NONE},
		'{ROW_FRAME, FLAW_RESTART,  1'b0, 8'h5A, 8'hC3, 1'b0, R_NONE},
		'{ROW_FRAME, FLAW_TIMEOUT,  1'b0, 8'h12, 8'h34, 1'b0, R_NONE},
		'{ROW_FRAME, FLAW_BAD,      1'b0, 8'h81, 8'h7E, 1'b0, R_NONE},
		'{ROW_FRAME, FLAW_NONE,     1'b0, 8'h01, 8'h80, 1'b0, R_NONE}
	};

	nec_ir_frame_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Width classes are tried in the order zero, one, leader.
	function automatic cls_t classify_width(input logic mode, input logic [WIDTH_W-1:0] w);
		if (mode)
			return CLS_TIMEOUT;
		if (w >= lim[REG_ZERO_MIN] && w <= lim[REG_ZERO_MAX])
			return CLS_ZERO;
		if (w >= lim[REG_ONE_MIN] && w <= lim[REG_ONE_MAX])
			return CLS_ONE;
		if (w >= lim[REG_LEADER_MIN] && w <= lim[REG_LEADER_MAX])
			return CLS_LEADER;
		return CLS_BAD;
	endfunction

	function automatic void drop_frame();
		rx_open  = 1'b0;
		rx_shift = '0;
		rx_bits  = 0;
		rx_bytes = 0;
		foreach (rx_buf[i])
			rx_buf[i] = '0;
	endfunction

	// Advances the reception state by one classified event and returns its word.
	function automatic result_t decode_event(input cls_t c);
		result_t r;
		r = '0;
		case (c)
		CLS_LEADER: begin
			drop_frame();
			rx_open = 1'b1;
		end
		CLS_ZERO, CLS_ONE: begin
			if (!rx_open) begin
				drop_frame();
				r.aborted = 1'b1;
			end else begin
				// Bits arrive LSB first, so each one enters at the top.
				rx_shift = {c == CLS_ONE, rx_shift[BYTE_W-1:1]};
				rx_bits++;
				if (rx_bits == BYTE_W) begin
					rx_buf[rx_bytes] = rx_shift;
					rx_shift = '0;
					rx_bits  = 0;
					rx_bytes++;
					if (rx_bytes == NBYTES) begin
						if (rx_buf[CMD_IDX] == ~rx_buf[CMD_IDX+1]) begin
							r.frame_ready = 1'b1;
							r.address     = rx_buf[0];
							r.command     = rx_buf[CMD_IDX];
						end else begin
							r.aborted = 1'b1;
						end
						drop_frame();
					end
				end
			end
		end
		default: begin
			drop_frame();
			r.aborted = 1'b1;
		end
		endcase
		r.receiving = rx_open;
		return r;
	endfunction

	// Picks a width of the wanted class under the current limits; an empty range
	// gives a random width.
	function automatic logic [WIDTH_W-1:0] pick_width(input cls_t c);
		logic [CFG_W-1:0]   lo;
		logic [CFG_W-1:0]   hi;
		logic [WIDTH_W-1:0] w;
		case (c)
		CLS_ZERO: begin
			lo = lim[REG_ZERO_MIN];
			hi = lim[REG_ZERO_MAX];
		end
		CLS_ONE: begin
			lo = lim[REG_ONE_MIN];
			hi = lim[REG_ONE_MAX];
		end
		CLS_LEADER: begin
			lo = lim[REG_LEADER_MIN];
			hi = lim[REG_LEADER_MAX];
		end
		default: begin
			w = '0;
			for (int k = 0; k < 32; k++) begin
				w = WIDTH_W'($urandom_range(255, 0));
				if (classify_width(1'b0, w) == CLS_BAD)
					return w;
			end
			return w;
		end
		endcase
		if (lo > hi)
			return WIDTH_W'($urandom_range(255, 0));
		return WIDTH_W'($urandom_range(hi, lo));
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		bad_words++;
		if (bad_words <= 10)
			$display("mismatch on word %0d, %s: expected %h, got %h",
				checked_words, what, want, got);
	endtask

	// Offers one word, records its decoded result once taken, then may idle a while.
	task automatic send_event(input logic mode, input logic [WIDTH_W-1:0] w,
			input logic typed = 1'b0, input result_t want = '0);
		result_t r;
		int      gap;
		s_tuser  <= mode;
		s_tdata  <= w;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		r = decode_event(classify_width(mode, w));
		decoded_q.push_back(typed ? want : r);
		sent_count++;
		gap = ((sent_count / 64) % 4 == 3) ? 0 : $urandom_range(11, 0);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Leader, then the frame bits with an optional flaw at one bit; a cut stops there.
	task automatic send_frame(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] cmd,
			input flaw_t flaw, input int flaw_at);
		logic [NBYTES-1:0][BYTE_W-1:0] body;
		for (int b = 0; b < NBYTES; b++)
			body[b] = BYTE_W'($urandom_range(255, 0));
		body[0]         = addr;
		body[CMD_IDX]   = cmd;
		body[CMD_IDX+1] = ~cmd;
		if (flaw == FLAW_MISMATCH)
			body[CMD_IDX+1] ^= BYTE_W'(1 << $urandom_range(BYTE_W - 1, 0));
		send_event(1'b0, pick_width(CLS_LEADER));
		for (int i = 0; i < BYTE_W * NBYTES; i++) begin
			if (i == flaw_at) begin
				case (flaw)
				FLAW_TIMEOUT: send_event(1'b1, WIDTH_W'($urandom_range(255, 0)));
				FLAW_BAD:     send_event(1'b0, pick_width(CLS_BAD));
				FLAW_RESTART: send_event(1'b0, pick_width(CLS_LEADER));
				FLAW_CUT:     return;
				default:      ;
				endcase
			end
			send_event(1'b0, pick_width(body[i / BYTE_W][i % BYTE_W] ? CLS_ONE : CLS_ZERO));
		end
	endtask

	// Drops valid and waits until every decoded word has come back.
	task automatic park_sender(input int settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic load_limits(input limits_t v, input bit poke_spare);
		// Indexes past the last register must leave every limit alone.
		if (poke_spare) begin
			for (int k = 0; k < 2; k++) begin
				cfg_we    <= 1'b1;
				cfg_index <= CFG_IDX_W'(REG_COUNT + k);
				cfg_data  <= CFG_W'($urandom_range(255, 0));
				@(posedge clk);
			end
		end
		for (int i = 0; i < REG_COUNT; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= v[i];
			@(posedge clk);
			lim[i] = v[i];
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stimulus: directed table, then random traffic under each limit setting.
	initial begin
		int     phase_end;
		int     sel;
		int     lo_v;
		bit     held;
		bit     paused;
		flaw_t  flaw;
		held   = 1'b0;
		paused = 1'b0;
		foreach (rx_buf[i])
			rx_buf[i] = '0;

		plan[0] = '{RST_ZERO_MIN, RST_ZERO_MAX, RST_ONE_MIN, RST_ONE_MAX,
			RST_LEADER_MIN, RST_LEADER_MAX};
		plan[1] = '{8'd0, 8'd40, 8'd41, 8'd120, 8'd121, 8'd255};
		plan[2] = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd1, 8'd254};
		plan[3] = '{8'd10, 8'd200, 8'd100, 8'd250, 8'd0, 8'd255};
		plan[EMPTY_PLAN] = '{8'd50, 8'd60, 8'd90, 8'd80, 8'd255, 8'd0};
		for (int k = EMPTY_PLAN + 1; k < NPLAN - 1; k++) begin
			lo_v = $urandom_range(30, 0);
			plan[k][REG_ZERO_MIN]   = CFG_W'(lo_v);
			plan[k][REG_ZERO_MAX]   = CFG_W'(lo_v + $urandom_range(40, 0));
			plan[k][REG_ONE_MIN]    =
				CFG_W'(plan[k][REG_ZERO_MAX] + 1 + $urandom_range(20, 0));
			plan[k][REG_ONE_MAX]    = CFG_W'(plan[k][REG_ONE_MIN] + $urandom_range(40, 0));
			plan[k][REG_LEADER_MIN] =
				CFG_W'(plan[k][REG_ONE_MAX] + 1 + $urandom_range(20, 0));
			plan[k][REG_LEADER_MAX] =
				CFG_W'(plan[k][REG_LEADER_MIN] + $urandom_range(40, 0));
		end
		plan[NPLAN-1] = plan[0];

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NPLAN; ph++) begin
			if (ph == 0) begin
				foreach (dir_rows[i]) begin
					if (dir_rows[i].kind == ROW_EVENT)
						send_event(dir_rows[i].mode, dir_rows[i].width,
							dir_rows[i].typed, dir_rows[i].want);
					else
						send_frame(dir_rows[i].width, dir_rows[i].cmd, dir_rows[i].flaw,
							$urandom_range(BYTE_W * NBYTES - 1, 0));
				end
			end else begin
				park_sender(SETTLE_CYCLES);
				load_limits(plan[ph], ph == NPLAN - 1);
			end

			phase_end = sent_count + ((ph == EMPTY_PLAN) ? EMPTY_ITEMS : PHASE_ITEMS);
			while (sent_count < phase_end) begin
				// Once, stall the output long enough to back the block up to its input.
				if (!held && sent_count >= HOLD_AT) begin
					hold_req = 1'b1;
					held     = 1'b1;
				end
				// Once, let the block drain completely in the middle of a phase.
				if (!paused && sent_count >= PAUSE_AT) begin
					park_sender(0);
					paused = 1'b1;
				end
				sel = $urandom_range(99, 0);
				if (sel < 70) begin
					if (sel < 8)
						flaw = FLAW_MISMATCH;
					else if (sel < 11)
						flaw = FLAW_TIMEOUT;
					else if (sel < 14)
						flaw = FLAW_BAD;
					else if (sel < 17)
						flaw = FLAW_RESTART;
					else if (sel < 20)
						flaw = FLAW_CUT;
					else
						flaw = FLAW_NONE;
					send_frame(BYTE_W'($urandom_range(255, 0)), BYTE_W'($urandom_range(255, 0)),
						flaw, $urandom_range(BYTE_W * NBYTES - 1, 0));
				end else if (sel < 88) begin
					send_event($urandom_range(7, 0) == 0, WIDTH_W'($urandom_range(255, 0)));
				end else begin
					send_event(1'b0, pick_width(noise_cls[$urandom_range(3, 0)]));
				end
			end
		end

		park_sender(DRAIN_CYCLES);
		if (bad_words == 0 && decoded_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Result side: random ready gaps, plus one long hold-off on request.
	initial begin
		int gap;
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = ((taken_count / 48) % 4 == 1) ? 0 : $urandom_range(11, 0);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken_count++;
		end
	end

	// Each taken word is compared with the oldest decoded result.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			checked_words++;
			got = m_tdata[RESULT_W-1:0];
			if (decoded_q.size() == 0) begin
				note_mismatch("unexpected word", '0, 32'(m_tdata));
			end else begin
				want = decoded_q.pop_front();
				if (got.frame_ready !== want.frame_ready)
					note_mismatch("frame_ready", 32'(want.frame_ready), 32'(got.frame_ready));
				if (got.address !== want.address)
					note_mismatch("address", 32'(want.address), 32'(got.address));
				if (got.command !== want.command)
					note_mismatch("command", 32'(want.command), 32'(got.command));
				if (got.receiving !== want.receiving)
					note_mismatch("receiving", 32'(want.receiving), 32'(got.receiving));
				if (got.aborted !== want.aborted)
					note_mismatch("aborted", 32'(want.aborted), 32'(got.aborted));
				if (m_tdata[OUT_TDATA_W-1:RESULT_W] !== '0)
					note_mismatch("pad bits", '0, 32'(m_tdata[OUT_TDATA_W-1:RESULT_W]));
			end
		end
	end

	// Ends the run if no word moves and no register is written for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
